### src/rpwr_pkg.sv
package rpwr_pkg;

    // Field and register widths
    localparam int RND_W  = 16;
    localparam int TIDX_W = 4;
    localparam int CFG_W  = 5;
    localparam int CNT_W  = 5;
    localparam int CIDX_W = 2;

    // Saturation value of the fired counter
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_TARGET_COUNT = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_UNIQUE_MODE  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_REUSABLE     = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COUNT,
        ST_RANK,
        ST_SEARCH,
        ST_COMMIT,
        ST_EMPTY
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;      // latch random word, clear scan counters
        logic count_step;   // first pass: count eligible targets
        logic calc_rank;    // compute rank, rewind scan
        logic search_step;  // second pass: walk to the ranked target
        logic commit;       // update round state, load result with a pick
        logic no_pick;      // load result with no pick
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic reject;       // no targets or round over without reuse
        logic last;         // scan index at the last target in use
        logic elig_zero;    // nothing eligible
        logic hit;          // current target is the ranked one
    } t_dp_status;

endpackage

### src/rpwr_dp.sv
module rpwr_dp #(
    parameter int TARGET_SLOTS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rpwr_pkg::CIDX_W-1:0]         i_cfg_index,
    input  logic [rpwr_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic [rpwr_pkg::RND_W-1:0]          i_random_word,
    input  rpwr_pkg::t_dp_cmd                   i_cmd,
    output rpwr_pkg::t_dp_status                o_status,
    output logic                                o_picked,
    output logic [rpwr_pkg::TIDX_W-1:0]         o_target_index,
    output logic                                o_round_reset
);

    localparam int CLAMP_INT = (TARGET_SLOTS < 31) ? TARGET_SLOTS : 31;
    localparam logic [rpwr_pkg::CFG_W-1:0] CLAMP = rpwr_pkg::CFG_W'(CLAMP_INT);
    localparam int PROD_W = rpwr_pkg::RND_W + rpwr_pkg::CNT_W;
    localparam logic [TARGET_SLOTS-1:0] ONE = {{(TARGET_SLOTS-1){1'b0}}, 1'b1};

    // Configuration registers
    logic [rpwr_pkg::CFG_W-1:0] r_target_count;
    logic                       r_unique_mode;
    logic                       r_reusable;

    // Round state
    logic [TARGET_SLOTS-1:0]    r_fired_mask;
    logic [rpwr_pkg::CNT_W-1:0] r_fired_count;

    // Per-request working registers
    logic [rpwr_pkg::RND_W-1:0] r_rnd;
    logic [rpwr_pkg::CFG_W-1:0] r_idx;
    logic [rpwr_pkg::CNT_W-1:0] r_elig;
    logic [rpwr_pkg::CNT_W-1:0] r_rank;
    logic [rpwr_pkg::CNT_W-1:0] r_seen;
    logic [rpwr_pkg::CFG_W-1:0] r_pick;

    // Result registers
    logic                        r_picked;
    logic [rpwr_pkg::TIDX_W-1:0] r_target_index;
    logic                        r_round_reset;

    logic [rpwr_pkg::CFG_W-1:0] tc_eff;
    logic [TARGET_SLOTS-1:0]    mask_sh;
    logic                       elig_bit;
    logic [PROD_W-1:0]          prod;
    logic [rpwr_pkg::CNT_W-1:0] cnt_inc;
    logic                       wrap;
    logic [TARGET_SLOTS-1:0]    mask_set;

    // Effective target count, clamped to the slot count
    assign tc_eff = (r_target_count > CLAMP) ? CLAMP : r_target_count;

    // Eligibility of the target under the scan index
    assign mask_sh  = r_fired_mask >> r_idx;
    assign elig_bit = !(r_unique_mode && mask_sh[0]);

    // Rank among eligible targets
    assign prod = PROD_W'(r_rnd) * PROD_W'(r_elig);

    // Round update on a pick
    assign cnt_inc  = (r_fired_count < rpwr_pkg::CNT_MAX) ? r_fired_count + 1'b1
                                                          : r_fired_count;
    assign wrap     = r_reusable && (cnt_inc >= tc_eff);
    assign mask_set = r_unique_mode ? (r_fired_mask | (ONE << r_pick)) : r_fired_mask;

    // Status to controller
    always_comb begin
        o_status.reject    = (tc_eff == '0)
                             || ((r_fired_count >= tc_eff) && !r_reusable);
        o_status.last      = (r_idx == tc_eff - 1'b1);
        o_status.elig_zero = (r_elig == '0);
        o_status.hit       = elig_bit && (r_seen == r_rank);
    end

    // Configuration and round state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_count <= '0;
            r_unique_mode  <= 1'b0;
            r_reusable     <= 1'b0;
            r_fired_mask   <= '0;
            r_fired_count  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rpwr_pkg::CFG_TARGET_COUNT: r_target_count <= i_cfg_data;
                    rpwr_pkg::CFG_UNIQUE_MODE:  r_unique_mode  <= i_cfg_data[0];
                    rpwr_pkg::CFG_REUSABLE:     r_reusable     <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_fired_mask  <= wrap ? '0 : mask_set;
                r_fired_count <= wrap ? '0 : cnt_inc;
            end
        end
    end

    // Scan datapath and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rnd  <= i_random_word;
            r_idx  <= '0;
            r_elig <= '0;
        end
        if (i_cmd.count_step) begin
            r_idx <= r_idx + 1'b1;
            if (elig_bit) begin
                r_elig <= r_elig + 1'b1;
            end
        end
        if (i_cmd.calc_rank) begin
            r_rank <= prod[PROD_W-1:rpwr_pkg::RND_W];
            r_idx  <= '0;
            r_seen <= '0;
        end
        if (i_cmd.search_step) begin
            r_idx <= r_idx + 1'b1;
            if (elig_bit) begin
                r_seen <= r_seen + 1'b1;
            end
            if (o_status.hit) begin
                r_pick <= r_idx;
            end
        end
        if (i_cmd.commit) begin
            r_picked       <= 1'b1;
            r_target_index <= r_pick[rpwr_pkg::TIDX_W-1:0];
            r_round_reset  <= wrap;
        end else if (i_cmd.no_pick) begin
            r_picked       <= 1'b0;
            r_target_index <= '0;
            r_round_reset  <= 1'b0;
        end
    end

    assign o_picked       = r_picked;
    assign o_target_index = r_target_index;
    assign o_round_reset  = r_round_reset;

endmodule

### src/rpwr_ctrl.sv
module rpwr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_stall,
    input  rpwr_pkg::t_dp_status i_status,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output rpwr_pkg::t_dp_cmd    o_cmd
);

    rpwr_pkg::t_state r_state;
    rpwr_pkg::t_state n_state;
    logic             r_out_valid;
    logic             out_free;
    logic             accept;

    assign o_in_stall = (r_state != rpwr_pkg::ST_IDLE) || !i_rst_n;
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rpwr_pkg::ST_IDLE:   if (accept) n_state = rpwr_pkg::ST_CHECK;
            rpwr_pkg::ST_CHECK:  n_state = i_status.reject ? rpwr_pkg::ST_EMPTY
                                                           : rpwr_pkg::ST_COUNT;
            rpwr_pkg::ST_COUNT:  if (i_status.last) n_state = rpwr_pkg::ST_RANK;
            rpwr_pkg::ST_RANK:   n_state = i_status.elig_zero ? rpwr_pkg::ST_EMPTY
                                                              : rpwr_pkg::ST_SEARCH;
            rpwr_pkg::ST_SEARCH: if (i_status.hit) n_state = rpwr_pkg::ST_COMMIT;
            rpwr_pkg::ST_COMMIT: if (out_free) n_state = rpwr_pkg::ST_IDLE;
            rpwr_pkg::ST_EMPTY:  if (out_free) n_state = rpwr_pkg::ST_IDLE;
            default:             n_state = rpwr_pkg::ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            rpwr_pkg::ST_IDLE:   o_cmd.capture     = accept;
            rpwr_pkg::ST_CHECK:  ;
            rpwr_pkg::ST_COUNT:  o_cmd.count_step  = 1'b1;
            rpwr_pkg::ST_RANK:   o_cmd.calc_rank   = 1'b1;
            rpwr_pkg::ST_SEARCH: o_cmd.search_step = 1'b1;
            rpwr_pkg::ST_COMMIT: o_cmd.commit      = out_free;
            rpwr_pkg::ST_EMPTY:  o_cmd.no_pick     = out_free;
            default: ;
        endcase
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpwr_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit || o_cmd.no_pick) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### src/random_pick_without_repeat_top.sv
// Random pick without repeat: each request word picks one of the first target_count
// targets, uniformly among those still eligible (in unique mode, targets already fired
// this round are skipped). One result per request; picked is 0 when no target can be
// chosen. A control FSM runs two one-slot-per-cycle passes over the fired mask, one to
// count eligible targets and one that stops at the ranked target, with a rank multiply
// step (the RANK state) between them. A request rejected up front goes from CHECK
// straight to EMPTY; one with nothing eligible reaches EMPTY after the count pass and
// the rank step. The next request is taken once the result is in the output register.
// Configuration writes are accepted outside reset and must be made while no request is
// active.
module random_pick_without_repeat_top #(
    parameter int TARGET_SLOTS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rpwr_pkg::RND_W-1:0]          i_random_word,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_picked,
    output logic [rpwr_pkg::TIDX_W-1:0]         o_target_index,
    output logic                                o_round_reset,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rpwr_pkg::CIDX_W-1:0]         i_cfg_index,
    input  logic [rpwr_pkg::CFG_W-1:0]          i_cfg_data
);

    rpwr_pkg::t_dp_cmd    cmd;
    rpwr_pkg::t_dp_status status;
    logic                 cfg_we;

    assign o_cfg_ready = i_rst_n;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    rpwr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    rpwr_dp #(
        .TARGET_SLOTS (TARGET_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_random_word  (i_random_word),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_picked       (o_picked),
        .o_target_index (o_target_index),
        .o_round_reset  (o_round_reset)
    );

`ifndef SYNTHESIS
    // a request transfer always makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after request transfer");

    // an empty result carries zero index and no round reset
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_picked) |-> (o_target_index == '0 && !o_round_reset))
        else $error("empty result with nonzero fields");

    // a round can only complete on an actual pick
    a_round_needs_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_round_reset) |-> o_picked)
        else $error("round reset without a pick");

    // datapath never gets a pick and an empty result at once
    a_one_result_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.commit && cmd.no_pick))
        else $error("conflicting result commands");
`endif

endmodule

### verif/random_pick_without_repeat_top_tb.sv
`timescale 1ns / 100ps

module random_pick_without_repeat_top_tb;

    localparam int SLOTS     = 16;
    // Drain wait after the last pick; longer than the worst-case request latency
    localparam int DRAIN_GAP = 40;
    localparam int HOLD_LEN  = 300;
    localparam int SEGMENTS  = 34;
    localparam int SEG_ITEMS = 30;

    // Index with no register behind it
    localparam logic [rpwr_pkg::CIDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic                         picked;
        logic [rpwr_pkg::TIDX_W-1:0]  target_index;
        logic                         round_reset;
    } t_pick;

    // Round state mirror plus queue of expected picks
    class t_pick_scoreboard;
        logic [rpwr_pkg::CFG_W-1:0]  target_count;
        logic                        unique_on;
        logic                        reuse_on;
        logic [SLOTS-1:0]            fired_mask;
        logic [rpwr_pkg::CNT_W-1:0]  fired_count;
        t_pick                       expected_picks[$];
        int                          errors;

        function new();
            target_count = '0;
            unique_on    = 1'b0;
            reuse_on     = 1'b0;
            fired_mask   = '0;
            fired_count  = '0;
            errors       = 0;
        endfunction

        function void apply_config(logic [rpwr_pkg::CIDX_W-1:0] idx,
                                   logic [rpwr_pkg::CFG_W-1:0] data);
            case (idx)
                rpwr_pkg::CFG_TARGET_COUNT: target_count = data;
                rpwr_pkg::CFG_UNIQUE_MODE:  unique_on    = data[0];
                rpwr_pkg::CFG_REUSABLE:     reuse_on     = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_picks.size();
        endfunction

        // Work out the pick for one accepted request and advance the round state
        function void note_request(logic [rpwr_pkg::RND_W-1:0] rnd);
            int    tc;
            int    eligible;
            int    rank;
            int    seen;
            int    hit;
            t_pick res;
            res = '0;
            hit = -1;
            tc  = (target_count > SLOTS) ? SLOTS : int'(target_count);
            if (tc != 0 && (fired_count < tc || reuse_on)) begin
                eligible = 0;
                for (int i = 0; i < tc; i++)
                    if (!(unique_on && fired_mask[i])) eligible++;
                if (eligible != 0) begin
                    rank = (int'(rnd) * eligible) >> 16;
                    seen = 0;
                    for (int i = 0; i < tc; i++) begin
                        if (unique_on && fired_mask[i]) continue;
                        if (seen == rank) begin
                            hit = i;
                            break;
                        end
                        seen++;
                    end
                end
            end
            if (hit >= 0) begin
                if (unique_on) fired_mask[hit] = 1'b1;
                if (fired_count < rpwr_pkg::CNT_MAX) fired_count++;
                // round complete: start over
                if (fired_count >= tc && reuse_on) begin
                    fired_count     = '0;
                    fired_mask      = '0;
                    res.round_reset = 1'b1;
                end
                res.picked       = 1'b1;
                res.target_index = hit[rpwr_pkg::TIDX_W-1:0];
            end
            expected_picks.push_back(res);
        endfunction

        function void check_pick(logic got_picked,
                                 logic [rpwr_pkg::TIDX_W-1:0] got_index,
                                 logic got_reset);
            t_pick want;
            if (expected_picks.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: picked=%0d index=%0d round_reset=%0d",
                             got_picked, got_index, got_reset);
                return;
            end
            want = expected_picks.pop_front();
            if (got_picked !== want.picked || got_index !== want.target_index ||
                got_reset !== want.round_reset) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch picked/index/round_reset: exp %0d %0d %0d got %0d %0d %0d",
                             want.picked, want.target_index, want.round_reset,
                             got_picked, got_index, got_reset);
            end
        endfunction
    endclass

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_stall;
    logic [rpwr_pkg::RND_W-1:0]    i_random_word  = '0;
    logic                          o_out_valid;
    logic                          i_out_stall    = 1'b0;
    logic                          o_picked;
    logic [rpwr_pkg::TIDX_W-1:0]   o_target_index;
    logic                          o_round_reset;
    logic                          i_cfg_valid    = 1'b0;
    logic                          o_cfg_ready;
    logic [rpwr_pkg::CIDX_W-1:0]   i_cfg_index    = '0;
    logic [rpwr_pkg::CFG_W-1:0]    i_cfg_data     = '0;

    t_pick_scoreboard picks = new();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit pressure_on   = 1'b0;
    bit hold_done     = 1'b0;
    int hold_left     = 0;

    random_pick_without_repeat_top #(
        .TARGET_SLOTS (SLOTS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_random_word  (i_random_word),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_picked       (o_picked),
        .o_target_index (o_target_index),
        .o_round_reset  (o_round_reset),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result-side stall: random, plus one long hold-off when requested
    always @(posedge i_clk) begin
        if (pressure_on && !hold_done) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watch every transfer on the three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                picks.check_pick(o_picked, o_target_index, o_round_reset);
            if (i_in_valid && !o_in_stall)
                picks.note_request(i_random_word);
            if (i_cfg_valid && o_cfg_ready)
                picks.apply_config(i_cfg_index, i_cfg_data);
        end
    end

    // One register write; valid is left high for a following write
    task automatic put_reg(input logic [rpwr_pkg::CIDX_W-1:0] idx,
                           input logic [rpwr_pkg::CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input logic [rpwr_pkg::CFG_W-1:0] tc,
                             input logic [rpwr_pkg::CFG_W-1:0] uq,
                             input logic [rpwr_pkg::CFG_W-1:0] ru,
                             input bit touch_unused);
        put_reg(rpwr_pkg::CFG_TARGET_COUNT, tc);
        put_reg(rpwr_pkg::CFG_UNIQUE_MODE, uq);
        put_reg(rpwr_pkg::CFG_REUSABLE, ru);
        if (touch_unused) put_reg(CFG_UNUSED, rpwr_pkg::CFG_W'($urandom_range(31)));
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one request word, with an optional idle gap first
    task automatic send_word(input logic [rpwr_pkg::RND_W-1:0] word);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_random_word <= word;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and wait until every pick has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        // the last transfer is noted at the edge just passed, so wait for an edge before checking
        do @(posedge i_clk); while (picks.pending() != 0);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    function automatic logic [rpwr_pkg::RND_W-1:0] draw_word();
        case ($urandom_range(19))
            0:       return '0;
            1:       return '1;
            default: return rpwr_pkg::RND_W'($urandom);
        endcase
    endfunction

    function automatic logic [rpwr_pkg::CFG_W-1:0] draw_count();
        case ($urandom_range(9))
            0:       return '0;
            1:       return rpwr_pkg::CFG_W'($urandom_range(17, 31));
            2:       return rpwr_pkg::CFG_W'(SLOTS);
            3:       return rpwr_pkg::CFG_W'(1);
            default: return rpwr_pkg::CFG_W'($urandom_range(1, SLOTS));
        endcase
    endfunction

    initial begin
        logic [rpwr_pkg::CFG_W-1:0] uq_data;
        logic [rpwr_pkg::CFG_W-1:0] ru_data;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No targets right after reset
        send_word('1);
        settle();

        // Clamped count, plain picks at the rank extremes
        configure(5'd31, 5'd0, 5'd0, 1'b0);
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'h8000);
        settle();

        // Count already at a lowered target with reuse: counts, then clears
        configure(5'd3, 5'd0, 5'd1, 1'b0);
        send_word(16'h5555);
        settle();

        // Unique mode marks the lowest three; upper data bits must be ignored
        configure(5'd16, 5'h1F, 5'h1E, 1'b0);
        send_word(16'h0000);
        send_word(16'h0000);
        send_word(16'h0000);
        settle();

        // Every target in use already marked: nothing eligible
        configure(5'd2, 5'd1, 5'd1, 1'b0);
        send_word(16'hFFFF);
        settle();

        // Single eligible target, then the round is over without reuse
        configure(5'd4, 5'd1, 5'd0, 1'b0);
        send_word(16'h1234);
        send_word(16'hFFFF);
        settle();

        // Outside unique mode the marked target counts again; unused index write
        configure(5'd1, 5'd0, 5'd1, 1'b1);
        send_word(16'hFFFF);
        settle();

        // One full unique round with reuse
        configure(5'd5, 5'd1, 5'd1, 1'b0);
        repeat (5) send_word(rpwr_pkg::RND_W'($urandom));
        settle();

        // Random segments, rotating through the idle patterns
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 72; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            uq_data    = rpwr_pkg::CFG_W'($urandom_range(31));
            ru_data    = rpwr_pkg::CFG_W'($urandom_range(31));
            ru_data[0] = ($urandom_range(3) != 0);
            configure(draw_count(), uq_data, ru_data, ($urandom_range(7) == 0));
            // long result hold-off so the input side backs up
            if (seg == 4) pressure_on = 1'b1;
            repeat (SEG_ITEMS) send_word(draw_word());
            settle();
        end

        if (picks.errors == 0 && picks.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

### files.f
src/rpwr_pkg.sv
src/rpwr_dp.sv
src/rpwr_ctrl.sv
src/random_pick_without_repeat_top.sv
verif/random_pick_without_repeat_top_tb.sv
